>>> design/heliocentric_to_cartesian_top_macros.svh
// assertion macros shared by the design
`ifndef HELIOCENTRIC_TO_CARTESIAN_TOP_MACROS_SVH
`define HELIOCENTRIC_TO_CARTESIAN_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define H2C_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
	else $error("h2c assertion failed");
`define H2C_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
	else $error("h2c assertion failed");
`else
`define H2C_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define H2C_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

>>> design/h2c_pkg.sv
`default_nettype none
package h2c_pkg;
	localparam int CORDIC_STAGES_DEF = 24;
	localparam int LON_W = 25;
	localparam int LAT_W = 24;
	localparam int R_W = 32;
	localparam int OUT_W = 33;
	localparam int ANG_W = 27;  // degrees q16 after wrap
	localparam int Z_W = 34;    // degrees q24 inside the cordic
	localparam int XY_W = 34;   // q4.30
	localparam int PROD_W = 2 * XY_W;
	localparam int SPROD_W = R_W + 1 + XY_W;
	localparam int SCL_W = SPROD_W - 30;

	localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
	localparam logic signed [XY_W-1:0] SIN_OBL = XY_W'(427109969);
	localparam logic signed [XY_W-1:0] COS_OBL = XY_W'(985138863);
	localparam logic signed [ANG_W-1:0] DEG90 = ANG_W'(90 * 65536);
	localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(180 * 65536);
	localparam logic signed [ANG_W-1:0] DEG360 = ANG_W'(360 * 65536);
	localparam logic signed [SCL_W-1:0] OUT_MAX = SCL_W'(64'sd4294967295);
	localparam logic signed [SCL_W-1:0] OUT_MIN = -SCL_W'(64'sd4294967296);

	typedef struct packed {
		logic neg;
		logic signed [Z_W-1:0] z;
	} ang_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x_l;
		logic signed [XY_W-1:0] y_l;
		logic signed [Z_W-1:0] z_l;
		logic neg_l;
		logic signed [XY_W-1:0] x_b;
		logic signed [XY_W-1:0] y_b;
		logic signed [Z_W-1:0] z_b;
		logic neg_b;
		logic [R_W-1:0] r;
	} cordic_t;

	function automatic logic signed [Z_W-1:0] atan_q24(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0: v = 30'd754974720;
			5'd1: v = 30'd445687602;
			5'd2: v = 30'd235489088;
			5'd3: v = 30'd119537938;
			5'd4: v = 30'd60000934;
			5'd5: v = 30'd30029717;
			5'd6: v = 30'd15018523;
			5'd7: v = 30'd7509720;
			5'd8: v = 30'd3754917;
			5'd9: v = 30'd1877466;
			5'd10: v = 30'd938734;
			5'd11: v = 30'd469367;
			5'd12: v = 30'd234684;
			5'd13: v = 30'd117342;
			5'd14: v = 30'd58671;
			5'd15: v = 30'd29335;
			5'd16: v = 30'd14668;
			5'd17: v = 30'd7334;
			5'd18: v = 30'd3667;
			5'd19: v = 30'd1833;
			5'd20: v = 30'd917;
			5'd21: v = 30'd458;
			5'd22: v = 30'd229;
			5'd23: v = 30'd115;
			5'd24: v = 30'd57;
			5'd25: v = 30'd29;
			5'd26: v = 30'd14;
			5'd27: v = 30'd7;
			5'd28: v = 30'd4;
			5'd29: v = 30'd2;
			5'd30: v = 30'd1;
			default: v = 30'd0;
		endcase
		return $signed({{(Z_W-30){1'b0}}, v});
	endfunction

	// fold into -90..90, flag a half-turn
	function automatic ang_t fold_ang(input logic signed [ANG_W-1:0] a);
		ang_t res;
		logic signed [ANG_W-1:0] f;
		f = a;
		res.neg = 1'b0;
		if (a > DEG90) begin
			f = a - DEG180;
			res.neg = 1'b1;
		end else if (a < -DEG90) begin
			f = a + DEG180;
			res.neg = 1'b1;
		end
		res.z = Z_W'(f) <<< 8;
		return res;
	endfunction

	function automatic logic signed [XY_W-1:0] mul_q30(input logic signed [XY_W-1:0] a,
			input logic signed [XY_W-1:0] b);
		logic signed [PROD_W-1:0] p;
		p = (PROD_W'(a) * PROD_W'(b)) + PROD_W'(64'sd536870912);
		return XY_W'(p >>> 30);
	endfunction

	function automatic logic signed [SCL_W-1:0] scale_r(input logic [R_W-1:0] r,
			input logic signed [XY_W-1:0] f);
		logic signed [SPROD_W-1:0] p;
		p = (SPROD_W'($signed({1'b0, r})) * SPROD_W'(f)) + SPROD_W'(64'sd536870912);
		return SCL_W'(p >>> 30);
	endfunction

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SCL_W-1:0] v);
		if (v > OUT_MAX) begin
			return OUT_W'(OUT_MAX);
		end else if (v < OUT_MIN) begin
			return OUT_W'(OUT_MIN);
		end
		return OUT_W'(v);
	endfunction
endpackage
`default_nettype wire

>>> design/h2c_prep.sv
`default_nettype none
module h2c_prep
	import h2c_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [LON_W-1:0] longitude,
	input wire logic signed [LAT_W-1:0] latitude,
	input wire logic [R_W-1:0] radius,
	output logic out_valid,
	input wire logic out_ready,
	output cordic_t out_data
);
	logic v_q;
	cordic_t d_q;
	logic signed [ANG_W-1:0] lon_w;
	ang_t fl;
	ang_t fb;

	always_comb begin
		lon_w = $signed({{(ANG_W-LON_W){1'b0}}, longitude});
		if (lon_w >= DEG360) begin
			lon_w = lon_w - DEG360;
		end
		if (lon_w > DEG180) begin
			lon_w = lon_w - DEG360;
		end
		fl = fold_ang(lon_w);
		fb = fold_ang(ANG_W'(latitude));
	end

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_q.x_l <= CORDIC_GAIN;
			d_q.y_l <= '0;
			d_q.z_l <= fl.z;
			d_q.neg_l <= fl.neg;
			d_q.x_b <= CORDIC_GAIN;
			d_q.y_b <= '0;
			d_q.z_b <= fb.z;
			d_q.neg_b <= fb.neg;
			d_q.r <= radius;
		end
	end

	assign out_valid = v_q;
	assign out_data = d_q;
endmodule
`default_nettype wire

>>> design/h2c_cordic_cell.sv
`default_nettype none
module h2c_cordic_cell
	import h2c_pkg::*;
#(
	parameter int IDX = 0
)(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire cordic_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output cordic_t out_data
);
	localparam logic signed [Z_W-1:0] ATAN = atan_q24(5'(IDX));

	logic v_q;
	cordic_t d_q;
	cordic_t nx;

	// one micro-rotation on each lane
	always_comb begin
		nx = in_data;
		if (!in_data.z_l[Z_W-1]) begin
			nx.x_l = in_data.x_l - (in_data.y_l >>> IDX);
			nx.y_l = in_data.y_l + (in_data.x_l >>> IDX);
			nx.z_l = in_data.z_l - ATAN;
		end else begin
			nx.x_l = in_data.x_l + (in_data.y_l >>> IDX);
			nx.y_l = in_data.y_l - (in_data.x_l >>> IDX);
			nx.z_l = in_data.z_l + ATAN;
		end
		if (!in_data.z_b[Z_W-1]) begin
			nx.x_b = in_data.x_b - (in_data.y_b >>> IDX);
			nx.y_b = in_data.y_b + (in_data.x_b >>> IDX);
			nx.z_b = in_data.z_b - ATAN;
		end else begin
			nx.x_b = in_data.x_b + (in_data.y_b >>> IDX);
			nx.y_b = in_data.y_b - (in_data.x_b >>> IDX);
			nx.z_b = in_data.z_b + ATAN;
		end
	end

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_q <= nx;
		end
	end

	assign out_valid = v_q;
	assign out_data = d_q;
endmodule
`default_nettype wire

>>> design/h2c_rotate.sv
`default_nettype none
module h2c_rotate
	import h2c_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire cordic_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [OUT_W-1:0] x_pos,
	output logic signed [OUT_W-1:0] y_pos,
	output logic signed [OUT_W-1:0] z_pos
);
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic signed [XY_W-1:0] sl, cl, sb, cb;
	logic signed [XY_W-1:0] cc_s1, lc_s1, sb_s1;
	logic signed [XY_W-1:0] cc_s2, p1_s2, p2_s2, p3_s2, p4_s2;
	logic signed [XY_W-1:0] cc_s3, ty_s3, tz_s3;
	logic signed [SCL_W-1:0] sx_s4, sy_s4, sz_s4;
	logic [R_W-1:0] r_s1, r_s2, r_s3;
	logic signed [OUT_W-1:0] x_s5, y_s5, z_s5;

	assign sl = in_data.neg_l ? -in_data.y_l : in_data.y_l;
	assign cl = in_data.neg_l ? -in_data.x_l : in_data.x_l;
	assign sb = in_data.neg_b ? -in_data.y_b : in_data.y_b;
	assign cb = in_data.neg_b ? -in_data.x_b : in_data.x_b;

	assign rdy5 = !v_s5 || !out_stall;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			cc_s1 <= mul_q30(cl, cb);
			lc_s1 <= mul_q30(sl, cb);
			sb_s1 <= sb;
			r_s1 <= in_data.r;
		end
		if (rdy2 && v_s1) begin
			cc_s2 <= cc_s1;
			p1_s2 <= mul_q30(lc_s1, COS_OBL);
			p2_s2 <= mul_q30(sb_s1, SIN_OBL);
			p3_s2 <= mul_q30(lc_s1, SIN_OBL);
			p4_s2 <= mul_q30(sb_s1, COS_OBL);
			r_s2 <= r_s1;
		end
		if (rdy3 && v_s2) begin
			cc_s3 <= cc_s2;
			ty_s3 <= p1_s2 - p2_s2;
			tz_s3 <= p3_s2 + p4_s2;
			r_s3 <= r_s2;
		end
		if (rdy4 && v_s3) begin
			sx_s4 <= scale_r(r_s3, cc_s3);
			sy_s4 <= scale_r(r_s3, ty_s3);
			sz_s4 <= scale_r(r_s3, tz_s3);
		end
		if (rdy5 && v_s4) begin
			x_s5 <= sat_out(sx_s4);
			y_s5 <= sat_out(sy_s4);
			z_s5 <= sat_out(sz_s4);
		end
	end

	assign out_valid = v_s5;
	assign x_pos = x_s5;
	assign y_pos = y_s5;
	assign z_pos = z_s5;
endmodule
`default_nettype wire

>>> design/heliocentric_to_cartesian_top.sv
// ecliptic (longitude, latitude, radius) to equatorial x, y, z, j2000 obliquity
// input channel: in_valid / in_stall with longitude, latitude, radius
// output channel: out_valid / out_stall with x_pos, y_pos, z_pos
// a beat is taken when valid is high and stall is low at a rising edge
// the pipeline is one angle wrap stage, one cordic cell
// per stage (both angles rotate side by side in each cell), then five
// multiply, add, scale and saturate stages
// throughput is one beat per cycle while out_stall is low; every stage holds one item
// when out_stall is high the last stage holds; empty stages upstream keep
// filling, so in_stall rises only once the whole chain is full
// reset empties every stage; nothing else is kept between beats
`default_nettype none
`include "heliocentric_to_cartesian_top_macros.svh"
module heliocentric_to_cartesian_top
	import h2c_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [LON_W-1:0] longitude,
	input wire logic signed [LAT_W-1:0] latitude,
	input wire logic [R_W-1:0] radius,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [OUT_W-1:0] x_pos,
	output logic signed [OUT_W-1:0] y_pos,
	output logic signed [OUT_W-1:0] z_pos
);
	logic chain_v [CORDIC_STAGES+1];
	logic chain_rdy [CORDIC_STAGES+1];
	cordic_t chain_d [CORDIC_STAGES+1];
	logic prep_ready;

	h2c_prep u_prep (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(prep_ready),
		.longitude(longitude),
		.latitude(latitude),
		.radius(radius),
		.out_valid(chain_v[0]),
		.out_ready(chain_rdy[0]),
		.out_data(chain_d[0])
	);

	assign in_stall = !prep_ready;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		h2c_cordic_cell #(.IDX(g)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(chain_v[g]),
			.in_ready(chain_rdy[g]),
			.in_data(chain_d[g]),
			.out_valid(chain_v[g+1]),
			.out_ready(chain_rdy[g+1]),
			.out_data(chain_d[g+1])
		);
	end

	h2c_rotate u_rot (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(chain_v[CORDIC_STAGES]),
		.in_ready(chain_rdy[CORDIC_STAGES]),
		.in_data(chain_d[CORDIC_STAGES]),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.x_pos(x_pos),
		.y_pos(y_pos),
		.z_pos(z_pos)
	);

	// an empty output stage means every stage upstream can move
	`H2C_ASSERT_IMP(a_empty_no_stall, clk, arst_n, !out_valid, !in_stall)
	`H2C_ASSERT_IMP(a_drain_no_stall, clk, arst_n, !out_stall, !in_stall)
	`H2C_ASSERT_NEXT(a_accept_lands, clk, arst_n, in_valid && !in_stall, chain_v[0])
endmodule
`default_nettype wire
